[sv/aoatd_pkg.sv]
// Shared types, constants and arithmetic helpers of the AOA/TDOA measurement predictor.
package aoatd_pkg;

  localparam int SENSORS = 3;
  localparam int NMEAS   = 2 * SENSORS;

  // Field widths
  localparam int IN_W   = 368;             // packed input beat
  localparam int STEP_W = 16;
  localparam int SLOT_W = 3;
  localparam int SEL_W  = 12;
  localparam int REG_W  = 3;

  // Datapath widths
  localparam int D_W   = 33;               // coordinate difference
  localparam int A_W   = 26;               // prescaled difference
  localparam int SQ_W  = 52;               // sum of squares
  localparam int RT_W  = 26;               // square root
  localparam int REM_W = 30;               // square root remainder
  localparam int DI_W  = 34;               // distance
  localparam int DF_W  = 35;               // distance difference
  localparam int DP_W  = 50;               // drift times steps
  localparam int TC_W  = 51;               // bias plus drift term
  localparam int PH_W  = 51;               // scale times high part
  localparam int PL_W  = 49;               // scale times low part
  localparam int T1_W  = 52;               // scaled difference
  localparam int TS_W  = 53;               // value before saturation
  localparam int M_W   = 40;               // normalized vector
  localparam int C_W   = 43;               // rotation vector
  localparam int Z_W   = 34;               // Q2.30 angle accumulator

  // Pipeline shape
  localparam int CORDIC_ITERS = 24;
  localparam int CHAIN        = RT_W;      // stages after the normalizer
  localparam int NST          = 34;        // register stages up to the serializer

  localparam logic signed [D_W-1:0] PRESCALE_LIMIT     = 33'sd1966080;
  localparam logic signed [D_W-1:0] NEG_PRESCALE_LIMIT = -33'sd1966080;
  localparam int                    PRESCALE_SHIFT     = 7;
  localparam logic [M_W-1:0]        NORM_LIMIT         = 40'h40_0000_0000;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30        = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] ANGLE_ROUND        = 34'sd8192;
  localparam int                    ANGLE_SHIFT        = 14;

  localparam logic signed [TS_W-1:0] SAT_HI = 53'sh0_0000_7FFF_FFFF;
  localparam logic signed [TS_W-1:0] SAT_LO = 53'sh1F_FFFF_8000_0000;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  // Sensor pairs 1-2, 1-3, 2-3
  localparam int PAIR_A [SENSORS] = '{0, 0, 1};
  localparam int PAIR_B [SENSORS] = '{1, 2, 2};

  typedef enum logic [REG_W-1:0] {
    REG_SENSOR1_X   = 3'd0,
    REG_SENSOR1_Y   = 3'd1,
    REG_SENSOR2_X   = 3'd2,
    REG_SENSOR2_Y   = 3'd3,
    REG_SENSOR3_X   = 3'd4,
    REG_SENSOR3_Y   = 3'd5,
    REG_RANGE_SCALE = 3'd6,
    REG_MEAS_SELECT = 3'd7
  } reg_idx_t;

  localparam logic [31:0] RST_SENSOR_X [SENSORS] = '{32'h0000_0000, 32'hFFFE_0B3D,
                                                       32'hFE80_EE98};
  localparam logic [31:0] RST_SENSOR_Y [SENSORS] = '{32'h0000_0000, 32'hFD1C_2CCB,
                                                       32'hFFFD_B176};
  localparam logic [31:0]      RST_RANGE_SCALE = 32'h0001_0000;
  localparam logic [SEL_W-1:0] RST_MEAS_SELECT = '0;

  typedef struct packed {
    logic signed [M_W-1:0] x;
    logic signed [M_W-1:0] y;
    logic [M_W-1:0]        m;
    logic                  zero;
  } nrm_t;

  typedef struct packed {
    logic signed [C_W-1:0] x;
    logic signed [C_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
    logic [SQ_W-1:0]  val;
  } sqr_t;

  typedef struct packed {
    logic [SENSORS-1:0]            zero;
    logic [SENSORS-1:0]            pre;
    logic [SENSORS-1:0][31:0]      off;
    logic [SENSORS-1:0][TC_W-1:0]  tc;
  } side_t;

  // Double the vector by sh places while its larger magnitude stays short of the limit.
  function automatic nrm_t norm_step(input nrm_t n, input logic [5:0] sh);
    nrm_t r;
    r = n;
    if (n.m < (NORM_LIMIT >> sh)) begin
      r.x = n.x <<< sh;
      r.y = n.y <<< sh;
      r.m = n.m << sh;
    end
    return r;
  endfunction

  // Fold the left half plane into the right one.
  function automatic cord_t cordic_prep(input nrm_t n);
    cord_t c;
    c.x = C_W'(n.x);
    c.y = C_W'(n.y);
    c.z = '0;
    if (n.x < 0) begin
      if (n.y >= 0) begin
        c.x = C_W'(n.y);
        c.y = -C_W'(n.x);
        c.z = HALF_PI_Q30;
      end else begin
        c.x = -C_W'(n.y);
        c.y = C_W'(n.x);
        c.z = -HALF_PI_Q30;
      end
    end
    return c;
  endfunction

  // One vectoring micro-rotation.
  function automatic cord_t cordic_iter(input cord_t p, input int sh);
    cord_t c;
    if (p.y >= 0) begin
      c.x = p.x + (p.y >>> sh);
      c.y = p.y - (p.x >>> sh);
      c.z = p.z + ATAN_TAB[sh];
    end else begin
      c.x = p.x - (p.y >>> sh);
      c.y = p.y + (p.x >>> sh);
      c.z = p.z - ATAN_TAB[sh];
    end
    return c;
  endfunction

  // One result bit of the restoring square root.
  function automatic sqr_t sqrt_step(input sqr_t p);
    sqr_t             r;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {p.rem[REM_W-3:0], p.val[SQ_W-1 -: 2]};
    trial = REM_W'({p.root, 2'b01});
    r.val = p.val << 2;
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {p.root[RT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {p.root[RT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [TS_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/aoa_tdoa_measurement_predictor.sv]
// Top level of the AOA/TDOA measurement predictor: pipeline, registers and serializer.
//
// Usage:
//   Slave stream (s_*): one beat per particle carries position, pair biases, pair
//   drifts, angle offsets and the step index. Master stream (m_*): one beat per
//   selected measurement, in select-list order; tlast marks the particle's final one.
//   A particle whose select list is all zero produces no beat.
//   Config channel (cfg_*): always ready; write only while no particle is in flight.
// Path: a particle's beat is registered through every pipeline stage to the last
//   one, is loaded into the serializer from there once the serializer is free, and
//   its first result beat is then shown from the serializer's registers.
// Throughput: the 34-stage pipeline takes one particle per cycle while it is not
//   stalled; the serializer sends one beat per cycle while m_tready is high, one
//   beat per nonzero select code (at most six), and takes the next particle with
//   the last beat of the one before. The per-sensor square root (one result bit per
//   stage) and the CORDIC run side by side and set the pipeline depth.
// Reset: rst clears every valid bit and the serializer, and loads the register
//   defaults.
// Stall: while the receiver holds m_tready low, the serializer keeps its beat, the
//   pipeline freezes once its final stage is full, and s_tready drops. No beat is lost.
module aoa_tdoa_measurement_predictor
  import aoatd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // pos_x, pos_y, bias_pair0..2, drift_pair0..2, angle_offset0..2, step_index
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  // predicted_value
  output logic [31:0]       m_tdata,
  // slot
  output logic [SLOT_W-1:0] m_tuser,
  output logic              m_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [REG_W-1:0]  cfg_addr,
  input  logic [31:0]       cfg_data
);

  // ---------------------------------------------------------------- registers
  logic signed [31:0] sensor_x [SENSORS];
  logic signed [31:0] sensor_y [SENSORS];
  logic signed [31:0] range_scale;
  logic [SEL_W-1:0]   meas_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SENSORS; k++) begin
        sensor_x[k] <= RST_SENSOR_X[k];
        sensor_y[k] <= RST_SENSOR_Y[k];
      end
      range_scale <= RST_RANGE_SCALE;
      meas_sel    <= RST_MEAS_SELECT;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_addr))
        REG_SENSOR1_X:   sensor_x[0] <= cfg_data;
        REG_SENSOR1_Y:   sensor_y[0] <= cfg_data;
        REG_SENSOR2_X:   sensor_x[1] <= cfg_data;
        REG_SENSOR2_Y:   sensor_y[1] <= cfg_data;
        REG_SENSOR3_X:   sensor_x[2] <= cfg_data;
        REG_SENSOR3_Y:   sensor_y[2] <= cfg_data;
        REG_RANGE_SCALE: range_scale <= cfg_data;
        REG_MEAS_SELECT: meas_sel    <= cfg_data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [NST:1] vld;
  logic         adv;
  logic         ser_free;

  // Advance the whole pipeline unless its final stage is full and cannot unload.
  assign adv      = !vld[NST] || ser_free;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-1:1], s_tvalid};
    end
  end

  // ---------------------------------------------------------------- input fields
  logic signed [31:0]  in_pos_x, in_pos_y;
  logic signed [31:0]  in_bias  [SENSORS];
  logic signed [31:0]  in_drift [SENSORS];
  logic signed [31:0]  in_off   [SENSORS];
  logic [STEP_W-1:0]   in_step;

  always_comb begin
    in_pos_x = s_tdata[31:0];
    in_pos_y = s_tdata[63:32];
    for (int k = 0; k < SENSORS; k++) begin
      in_bias[k]  = s_tdata[64 + 32*k +: 32];
      in_drift[k] = s_tdata[160 + 32*k +: 32];
      in_off[k]   = s_tdata[256 + 32*k +: 32];
    end
    in_step = s_tdata[IN_W-1 -: STEP_W];
  end

  // ---------------------------------------------------------------- stage 1: differences
  logic signed [D_W-1:0] r1_dx [SENSORS];
  logic signed [D_W-1:0] r1_dy [SENSORS];
  logic signed [31:0]    r1_bias  [SENSORS];
  logic signed [31:0]    r1_drift [SENSORS];
  logic signed [31:0]    r1_off   [SENSORS];
  logic [STEP_W:0]       r1_steps;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        r1_dx[k]    <= D_W'(in_pos_x) - D_W'(sensor_x[k]);
        r1_dy[k]    <= D_W'(in_pos_y) - D_W'(sensor_y[k]);
        r1_bias[k]  <= in_bias[k];
        r1_drift[k] <= in_drift[k];
        r1_off[k]   <= in_off[k];
      end
      r1_steps <= (STEP_W+1)'(in_step) + (STEP_W+1)'(2);
    end
  end

  // ---------------------------------------------------------------- stage 2: prescale, coarse norm
  nrm_t                   n2_next [SENSORS];
  logic signed [A_W-1:0]  a_next  [SENSORS];
  logic signed [A_W-1:0]  b_next  [SENSORS];
  logic [SENSORS-1:0]     pre_next;
  logic signed [DP_W-1:0] dprod_next [SENSORS];

  always_comb begin
    for (int k = 0; k < SENSORS; k++) begin
      logic [D_W-1:0] ax, ay, mx;
      logic signed [D_W-1:0] sa, sb;
      nrm_t n;
      // the angle is taken of the vector (dy, dx)
      ax = r1_dy[k][D_W-1] ? $unsigned(-r1_dy[k]) : $unsigned(r1_dy[k]);
      ay = r1_dx[k][D_W-1] ? $unsigned(-r1_dx[k]) : $unsigned(r1_dx[k]);
      mx = (ax > ay) ? ax : ay;
      n.x    = M_W'(r1_dy[k]);
      n.y    = M_W'(r1_dx[k]);
      n.m    = M_W'(mx);
      n.zero = (mx == '0);
      n2_next[k] = norm_step(norm_step(n, 6'd32), 6'd16);

      pre_next[k] = (r1_dx[k] > PRESCALE_LIMIT) || (r1_dx[k] < NEG_PRESCALE_LIMIT) ||
                    (r1_dy[k] > PRESCALE_LIMIT) || (r1_dy[k] < NEG_PRESCALE_LIMIT);
      sa = pre_next[k] ? (r1_dx[k] >>> PRESCALE_SHIFT) : r1_dx[k];
      sb = pre_next[k] ? (r1_dy[k] >>> PRESCALE_SHIFT) : r1_dy[k];
      a_next[k] = sa[A_W-1:0];
      b_next[k] = sb[A_W-1:0];

      dprod_next[k] = r1_drift[k] * $signed({1'b0, r1_steps});
    end
  end

  nrm_t                   r2_n     [SENSORS];
  logic signed [A_W-1:0]  r2_a     [SENSORS];
  logic signed [A_W-1:0]  r2_b     [SENSORS];
  logic [SENSORS-1:0]     r2_pre;
  logic signed [DP_W-1:0] r2_dprod [SENSORS];
  logic signed [31:0]     r2_bias  [SENSORS];
  logic signed [31:0]     r2_off   [SENSORS];

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_n     <= n2_next;
      r2_a     <= a_next;
      r2_b     <= b_next;
      r2_pre   <= pre_next;
      r2_dprod <= dprod_next;
      r2_bias  <= r1_bias;
      r2_off   <= r1_off;
    end
  end

  // ---------------------------------------------------------------- stage 3: squares
  nrm_t                   r3_n   [SENSORS];
  logic [SQ_W-1:0]        r3_sqa [SENSORS];
  logic [SQ_W-1:0]        r3_sqb [SENSORS];
  logic [SENSORS-1:0]     r3_pre;
  logic signed [TC_W-1:0] r3_tc  [SENSORS];
  logic signed [31:0]     r3_off [SENSORS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        logic signed [SQ_W-1:0] pa, pb;
        pa = r2_a[k] * r2_a[k];
        pb = r2_b[k] * r2_b[k];
        r3_n[k]   <= norm_step(norm_step(r2_n[k], 6'd8), 6'd4);
        r3_sqa[k] <= $unsigned(pa);
        r3_sqb[k] <= $unsigned(pb);
        r3_tc[k]  <= TC_W'(r2_bias[k]) + TC_W'(r2_dprod[k]);
      end
      r3_pre <= r2_pre;
      r3_off <= r2_off;
    end
  end

  // ---------------------------------------------------------------- stage 4: sum, fine norm
  nrm_t            r4_n   [SENSORS];
  logic [SQ_W-1:0] r4_sum [SENSORS];
  side_t           r4_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        r4_n[k]         <= norm_step(norm_step(r3_n[k], 6'd2), 6'd1);
        r4_sum[k]       <= r3_sqa[k] + r3_sqb[k];
        r4_side.zero[k] <= r3_n[k].zero;
        r4_side.off[k]  <= r3_off[k];
        r4_side.tc[k]   <= r3_tc[k];
      end
      r4_side.pre <= r3_pre;
    end
  end

  // ---------------------------------------------------------------- stages 5..30: sqrt and CORDIC
  sqr_t  sq   [CHAIN][SENSORS];
  cord_t cr   [CORDIC_ITERS+1][SENSORS];
  side_t side [CHAIN];

  for (genvar j = 0; j < CHAIN; j++) begin : g_sqrt
    if (j == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv) begin
          side[0] <= r4_side;
          for (int k = 0; k < SENSORS; k++) begin
            sq[0][k] <= sqrt_step(sqr_t'{rem: '0, root: '0, val: r4_sum[k]});
          end
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (adv) begin
          side[j] <= side[j-1];
          for (int k = 0; k < SENSORS; k++) begin
            sq[j][k] <= sqrt_step(sq[j-1][k]);
          end
        end
      end
    end
  end

  for (genvar j = 0; j <= CORDIC_ITERS; j++) begin : g_cordic
    if (j == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int k = 0; k < SENSORS; k++) begin
            cr[0][k] <= cordic_prep(r4_n[k]);
          end
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int k = 0; k < SENSORS; k++) begin
            cr[j][k] <= cordic_iter(cr[j-1][k], j - 1);
          end
        end
      end
    end
  end

  // Round the Q2.30 angle to Q16.16 and add the offset (stage 30).
  logic signed [31:0] aoa [SENSORS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        logic signed [Z_W-1:0] zr;
        zr = cr[CORDIC_ITERS][k].z + ANGLE_ROUND;
        if (side[CORDIC_ITERS].zero[k]) begin
          zr = '0;
        end
        aoa[k] <= sat32(TS_W'(zr >>> ANGLE_SHIFT) +
                        TS_W'($signed(side[CORDIC_ITERS].off[k])));
      end
    end
  end

  // ---------------------------------------------------------------- stage 31: distance differences
  logic signed [DF_W-1:0] r31_diff [SENSORS];
  logic signed [TC_W-1:0] r31_tc   [SENSORS];
  logic signed [31:0]     r31_aoa  [SENSORS];
  logic [DI_W-1:0]        rng      [SENSORS];

  always_comb begin
    for (int k = 0; k < SENSORS; k++) begin
      rng[k] = DI_W'(sq[CHAIN-1][k].root);
      if (side[CHAIN-1].pre[k]) begin
        rng[k] = rng[k] << PRESCALE_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        r31_diff[k] <= $signed({1'b0, rng[PAIR_A[k]]}) - $signed({1'b0, rng[PAIR_B[k]]});
        r31_tc[k]   <= $signed(side[CHAIN-1].tc[k]);
      end
      r31_aoa <= aoa;
    end
  end

  // ---------------------------------------------------------------- stage 32: scale products
  logic signed [PH_W-1:0] r32_phi [SENSORS];
  logic signed [PL_W-1:0] r32_plo [SENSORS];
  logic signed [TC_W-1:0] r32_tc  [SENSORS];
  logic signed [31:0]     r32_aoa [SENSORS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        logic signed [DF_W-17:0] hi;
        logic signed [16:0]      lo;
        hi = r31_diff[k][DF_W-1:16];
        lo = $signed({1'b0, r31_diff[k][15:0]});
        r32_phi[k] <= range_scale * hi;
        r32_plo[k] <= range_scale * lo;
      end
      r32_tc  <= r31_tc;
      r32_aoa <= r31_aoa;
    end
  end

  // ---------------------------------------------------------------- stage 33: floor of scaled diff
  logic signed [T1_W-1:0] r33_t1  [SENSORS];
  logic signed [TC_W-1:0] r33_tc  [SENSORS];
  logic signed [31:0]     r33_aoa [SENSORS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        r33_t1[k] <= T1_W'(r32_phi[k]) + T1_W'(r32_plo[k] >>> 16);
      end
      r33_tc  <= r32_tc;
      r33_aoa <= r32_aoa;
    end
  end

  // ---------------------------------------------------------------- stage 34: TDOA sum
  logic signed [31:0] r34_val [NMEAS];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SENSORS; k++) begin
        r34_val[k]           <= r33_aoa[k];
        r34_val[SENSORS + k] <= sat32(TS_W'(r33_t1[k]) + TS_W'(r33_tc[k]));
      end
    end
  end

  // ---------------------------------------------------------------- output serializer
  // pend holds one bit per select-list entry still to send; the lowest goes next.
  logic signed [31:0] ser_val [NMEAS];
  logic [NMEAS-1:0]   pend;
  logic [NMEAS-1:0]   pend_drop;
  logic [NMEAS-1:0]   sel_mask;
  logic [2:0]         cur_pos;
  logic [1:0]         cur_code;
  logic [SLOT_W-1:0]  cur_slot;
  logic               load;

  always_comb begin
    cur_pos = '0;
    for (int i = NMEAS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        cur_pos = 3'(i);
      end
    end
    cur_code = meas_sel[2*cur_pos +: 2];
    cur_slot = ((cur_pos < 3'(SENSORS)) ? 3'd0 : 3'(SENSORS)) + {1'b0, cur_code} - 3'd1;
    for (int i = 0; i < NMEAS; i++) begin
      sel_mask[i] = (meas_sel[2*i +: 2] != 2'd0);
    end
  end

  assign pend_drop = pend & (pend - 1'b1);
  assign ser_free  = (pend == '0) || (m_tready && (pend_drop == '0));
  assign load      = vld[NST] && ser_free;

  assign m_tvalid = (pend != '0);
  assign m_tdata  = ser_val[cur_slot];
  assign m_tuser  = cur_slot;
  assign m_tlast  = (pend_drop == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= sel_mask;
    end else if (m_tvalid && m_tready) begin
      pend <= pend_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_val <= r34_val;
    end
  end

endmodule

[sim/aoa_tdoa_measurement_predictor_test.sv]
// Self-checking testbench for the AOA/TDOA measurement predictor.
module aoa_tdoa_measurement_predictor_test;
  import aoatd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;          // pipeline depth plus serializer, with margin
  localparam int HOLD_OFF_CYCLES = 300;

  // Select lists: six 2-bit codes, AOA slots first, then TDOA slots
  localparam logic [SEL_W-1:0] SEL_NONE = 12'h000;
  localparam logic [SEL_W-1:0] SEL_IN_ORDER = 12'hE79;  // 1,2,3 then 1,2,3
  localparam logic [SEL_W-1:0] SEL_ALL_THIRD = 12'hFFF; // every code 3, duplicates

  localparam logic [2:0] SLOT_AOA1 = 3'd0;
  localparam logic [2:0] SLOT_AOA2 = 3'd1;
  localparam logic [2:0] SLOT_AOA3 = 3'd2;
  localparam logic [2:0] SLOT_TDOA12 = 3'd3;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  // One particle, first field in the lowest bits of the beat
  typedef struct packed {
    logic [15:0] step_index;
    logic [2:0][31:0] angle_offset;
    logic [2:0][31:0] drift;
    logic [2:0][31:0] bias;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } particle_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0] slot;
    logic last;
  } meas_t;

  typedef struct {
    particle_t p;
    bit pinned;          // value of one slot typed in by hand
    logic [2:0] slot;
    logic [31:0] value;
  } row_t;

  localparam longint ARCTAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] m_tdata;
  logic [SLOT_W-1:0] m_tuser;
  logic m_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  aoa_tdoa_measurement_predictor dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file
  logic [31:0] sensor_x [SENSORS];
  logic [31:0] sensor_y [SENSORS];
  logic [31:0] scale_reg;
  logic [SEL_W-1:0] select_reg;

  meas_t pending_meas [$];
  int mismatches = 0;
  int particles_sent = 0;
  int meas_seen = 0;
  int cycles = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int burst_left = 4;
  row_t plan [$];

  // ---------------------------------------------------------------- arithmetic

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Euclidean range in Q16.16; coarse by 128 when either leg exceeds 30.0
  function automatic longint range_to(longint dx, longint dy);
    int s;
    longint a, b;
    s = (dx > 1966080 || dx < -1966080 || dy > 1966080 || dy < -1966080) ? 7 : 0;
    a = dx >>> s;
    b = dy >>> s;
    return longint'(int_sqrt(longint'(a * a + b * b))) <<< s;
  endfunction

  // Vectoring rotation: angle of (cx, cy) in Q2.30
  function automatic longint bearing_q30(longint cx, longint cy);
    longint z, t, m, nx, ny;
    z = 0;
    if (cx == 0 && cy == 0) return 0;
    m = cx < 0 ? -cx : cx;
    t = cy < 0 ? -cy : cy;
    if (t > m) m = t;
    while (m < 64'sd274877906944) begin
      m *= 2; cx *= 2; cy *= 2;
    end
    // fold the left half plane over by a quarter turn
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; z = 64'sd1686629713;
      end else begin
        t = cx; cx = -cy; cy = t; z = -64'sd1686629713;
      end
    end
    for (int i = 0; i < 24; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += ARCTAN_Q30[i];
      end else begin
        nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= ARCTAN_Q30[i];
      end
      cx = nx; cy = ny;
    end
    return z;
  endfunction

  function automatic longint scaled_diff(longint scale, longint d);
    longint hi, lo;
    hi = d >>> 16;
    lo = d - hi * 65536;
    return scale * hi + ((scale * lo) >>> 16);
  endfunction

  // Queue the measurements one particle must produce; return how many
  function automatic int predict_measurements(particle_t p);
    longint rng [SENSORS];
    longint val [NMEAS];
    longint dx, dy, steps;
    int pa [SENSORS], pb [SENSORS];
    logic [1:0] code;
    int n, idx;
    meas_t m;
    pa = '{0, 0, 1};
    pb = '{1, 2, 2};
    steps = longint'(p.step_index) + 2;
    for (int i = 0; i < SENSORS; i++) begin
      dx = sx32(p.pos_x) - sx32(sensor_x[i]);
      dy = sx32(p.pos_y) - sx32(sensor_y[i]);
      rng[i] = range_to(dx, dy);
      val[i] = clamp32(((bearing_q30(dy, dx) + 8192) >>> 14) + sx32(p.angle_offset[i]));
    end
    for (int k = 0; k < SENSORS; k++) begin
      val[SENSORS + k] = clamp32(scaled_diff(sx32(scale_reg), rng[pa[k]] - rng[pb[k]])
                                 + sx32(p.bias[k]) + sx32(p.drift[k]) * steps);
    end
    n = 0;
    for (int i = 0; i < NMEAS; i++) begin
      if (select_reg[2*i +: 2] != 2'd0) n++;
    end
    idx = 0;
    for (int i = 0; i < NMEAS; i++) begin
      code = select_reg[2*i +: 2];
      if (code != 2'd0) begin
        m.slot = 3'((i < SENSORS ? 0 : SENSORS) + int'(code) - 1);
        m.value = val[m.slot][31:0];
        idx++;
        m.last = (idx == n);
        pending_meas.push_back(m);
      end
    end
    return n;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Call just after a rising edge; leaves cfg_valid high for the next write
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic setup_block(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                             logic [31:0] y2, logic [31:0] x3, logic [31:0] y3,
                             logic [31:0] scale, logic [SEL_W-1:0] sel);
    write_reg(REG_SENSOR1_X, x1);
    write_reg(REG_SENSOR1_Y, y1);
    write_reg(REG_SENSOR2_X, x2);
    write_reg(REG_SENSOR2_Y, y2);
    write_reg(REG_SENSOR3_X, x3);
    write_reg(REG_SENSOR3_Y, y3);
    write_reg(REG_RANGE_SCALE, scale);
    write_reg(REG_MEAS_SELECT, {20'd0, sel});
    cfg_valid <= 1'b0;
    sensor_x = '{x1, x2, x3};
    sensor_y = '{y1, y2, y3};
    scale_reg = scale;
    select_reg = sel;
  endtask

  // Offer one particle; gaps between bursts are random
  task automatic send_particle(particle_t p, bit pinned, logic [2:0] slot,
                               logic [31:0] value);
    int n;
    s_tdata <= p;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    n = predict_measurements(p);
    particles_sent++;
    // overwrite the hand-typed slot so the predictor is checked against it too
    if (pinned) begin
      for (int i = pending_meas.size() - n; i < pending_meas.size(); i++) begin
        if (pending_meas[i].slot == slot) pending_meas[i].value = value;
      end
    end
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  // Drop valid and wait until every measurement has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 6))
      0: return MAX32;
      1: return MIN32;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 80 << 16)) - 32'(40 << 16);
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    int k;
    p.pos_x = rand_word();
    p.pos_y = rand_word();
    for (int i = 0; i < SENSORS; i++) begin
      p.bias[i] = rand_word();
      p.drift[i] = rand_word();
      p.angle_offset[i] = rand_word();
    end
    p.step_index = 16'($urandom_range(0, 65535));
    // now and then park the particle right on a sensor
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 2);
      p.pos_x = sensor_x[k];
      p.pos_y = sensor_y[k];
    end
    return p;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_particle(rand_particle(), 1'b0, 3'd0, 32'd0);
    drain();
  endtask

  task automatic add_row(particle_t p, bit pinned, logic [2:0] slot, logic [31:0] value);
    row_t r;
    r.p = p;
    r.pinned = pinned;
    r.slot = slot;
    r.value = value;
    plan.push_back(r);
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall pattern is redrawn at random from the cycle counter; a requested hold-off overrides it
  int stall_mode = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (cycles % 50 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) < 7);
        default: m_tready <= (cycles % 5 != 0);
      endcase
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin
    meas_t want;
    if (!rst && m_tvalid && m_tready) begin
      meas_seen++;
      if (pending_meas.size() == 0) begin
        $display("%0t: unexpected beat value=%h slot=%0d last=%b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = pending_meas.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
          mismatches++;
        end
        if (m_tuser !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, m_tuser);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_meas.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    particle_t d;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sensor layout, every measurement in list order
    setup_block(RST_SENSOR_X[0], RST_SENSOR_Y[0], RST_SENSOR_X[1], RST_SENSOR_Y[1],
                RST_SENSOR_X[2], RST_SENSOR_Y[2], RST_RANGE_SCALE, SEL_IN_ORDER);

    d = '0;                                         // on sensor one: angle 0
    add_row(d, 1'b1, SLOT_AOA1, 32'd0);
    d.pos_y = -32'sd65536;                          // straight below: angle pi
    add_row(d, 1'b0, 3'd0, 32'd0);
    d = '0; d.pos_x = 32'd65536; d.pos_y = 32'd65536; d.angle_offset[0] = MAX32;
    add_row(d, 1'b1, SLOT_AOA1, MAX32);             // positive angle saturates high
    d = '0; d.pos_x = -32'sd65536; d.pos_y = 32'd65536; d.angle_offset[0] = MIN32;
    add_row(d, 1'b1, SLOT_AOA1, MIN32);             // negative angle saturates low
    d = '0; d.bias[0] = MAX32; d.drift[0] = MAX32; d.step_index = 16'hFFFF;
    add_row(d, 1'b1, SLOT_TDOA12, MAX32);
    d = '0; d.bias[0] = MIN32; d.drift[0] = MIN32; d.step_index = 16'hFFFF;
    add_row(d, 1'b1, SLOT_TDOA12, MIN32);
    d = '0; d.pos_x = MAX32; d.pos_y = MAX32;
    add_row(d, 1'b0, 3'd0, 32'd0);
    d = '0; d.pos_x = MIN32; d.pos_y = MIN32;
    add_row(d, 1'b0, 3'd0, 32'd0);
    d = '0; d.pos_x = MAX32; d.pos_y = MIN32;
    d.angle_offset = {MAX32, MAX32, MAX32}; d.bias = {MAX32, MAX32, MIN32};
    d.drift = {MIN32, MAX32, MAX32};
    add_row(d, 1'b0, 3'd0, 32'd0);
    d = '1;
    add_row(d, 1'b0, 3'd0, 32'd0);
    d = '0; d.pos_x = RST_SENSOR_X[2]; d.pos_y = RST_SENSOR_Y[2];
    add_row(d, 1'b1, SLOT_AOA3, 32'd0);             // on sensor three
    d = '0; d.pos_x = RST_SENSOR_X[1]; d.pos_y = RST_SENSOR_Y[1];
    add_row(d, 1'b1, SLOT_AOA2, 32'd0);             // on sensor two
    d = '0; d.pos_x = 32'd1966080;                  // exactly 30.0: no prescale
    add_row(d, 1'b0, 3'd0, 32'd0);
    d.pos_x = 32'd1966081;                          // just past: prescaled
    add_row(d, 1'b0, 3'd0, 32'd0);
    d = '0; d.pos_x = -32'sd1966081; d.step_index = 16'hFFFF;
    add_row(d, 1'b0, 3'd0, 32'd0);
    foreach (plan[i]) send_particle(plan[i].p, plan[i].pinned, plan[i].slot, plan[i].value);
    drain();

    // Long receiver hold-off while particles keep coming: the pipeline fills up
    setup_block(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), rand_word(), SEL_IN_ORDER);
    hold_req = 1'b1;
    random_phase(60);

    // Extreme layout, maximum scale, duplicated codes
    setup_block(MAX32, MIN32, MIN32, MAX32, MAX32, MAX32, MAX32, SEL_ALL_THIRD);
    random_phase(20);

    // Most negative scale, sparse random select
    setup_block(MIN32, MIN32, 32'd0, 32'd0, 32'd65536, -32'sd65536, MIN32,
                12'($urandom_range(1, 4095)));
    random_phase(20);

    // Empty select list: particles produce nothing
    setup_block(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word(), 32'd0, SEL_NONE);
    random_phase(10);

    for (int ph = 0; ph < 3; ph++) begin
      setup_block(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word(), 12'($urandom_range(0, 4095)));
      random_phase(15);
    end

    $display("covered %0d particles and %0d measurement beats over eight register setups,",
             particles_sent, meas_seen);
    $display("including saturation, prescaled ranges, empty and repeated select codes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
